### design/b62e_pkg.sv
package b62e_pkg;

    // Field widths of the two channels.
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 5;
    localparam int CHAR_W  = 7;

    // Longest run of characters that one item can ask for.
    localparam int MAX_DIGITS = 16;
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    // Radix and the width of one base-62 digit value.
    localparam int RADIX = 62;
    localparam int REM_W = 6;

    // Long division works through the value one byte per step.
    localparam int CHUNK_W = 8;
    localparam int STEPS   = VALUE_W / CHUNK_W;
    localparam int STEP_W  = $clog2(STEPS);

    // Reciprocal of the radix, scaled by 2**RECIP_SHIFT and rounded down.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = (1 << RECIP_SHIFT) / RADIX;

    // ASCII offsets of the three alphabet bands.
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_BASE = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_BASE = 7'h41 - 7'd10;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_BASE = 7'h61 - 7'd36;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_READ,
        ST_SHOW,
        ST_ERROR
    } b62e_state_t;

    // Maps a digit value to its character in 0-9, A-Z, a-z.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] base;
        case (d) inside
            [6'd0:6'd9]:   base = CHAR_DIGIT_BASE;
            [6'd10:6'd35]: base = CHAR_UPPER_BASE;
            default:       base = CHAR_LOWER_BASE;
        endcase
        return base + CHAR_W'(d);
    endfunction

endpackage

### design/base62_fixed_width_encoder.sv
// Base-62 fixed-width encoder.
// An input beat (s_value, s_digit_count) is taken on the s_valid/s_ready
// handshake. The value comes back as exactly s_digit_count characters on
// the m_ channel, most significant first, from the alphabet 0-9, A-Z, a-z,
// padded with '0'. A count of zero is treated as one; counts above 16 are
// held at 16. If the value needs more digits than asked for, a single beat
// with m_too_large and m_last set and m_digit_char zero is sent instead.
// m_last marks the final beat of every run.
// Each digit is found by a long division by 62 in a shared divide step that
// takes one byte per cycle; once the remaining quotient is zero, each further
// digit is written as zero without dividing. After the divisions a check
// state tests for overflow, then each character passes through a read state
// and the digit store's read register before it is shown.
// One item is handled at a time: s_ready is high only when the block idles.
// A stalled receiver simply holds the block in its output state with the
// beat unchanged. Reset returns the block to idle with no beat pending.
module base62_fixed_width_encoder
    import b62e_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    input  logic [COUNT_W-1:0] s_digit_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_digit_char,
    output logic               m_last,
    output logic               m_too_large
);

    b62e_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] n_reg, n_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   last_idx_reg, last_idx_next;

    logic [REM_W-1:0]   digit_mem [MAX_DIGITS];
    logic [REM_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic [REM_W-1:0]   mem_wdata;

    logic [REM_W-1:0]   div_rem_in;
    logic [CHUNK_W-1:0] div_quo;
    logic [REM_W-1:0]   div_rem_out;
    logic               zero_skip;
    logic               last_step;
    logic               digit_done;
    logic               in_beat;
    logic               out_beat;
    logic [IDX_W-1:0]   count_last;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Index of the final character, with the count held to 1..MAX_DIGITS.
    always_comb begin
        if (s_digit_count == '0) begin
            count_last = '0;
        end else if (int'(s_digit_count) > MAX_DIGITS) begin
            count_last = IDX_W'(MAX_DIGITS - 1);
        end else begin
            count_last = IDX_W'(s_digit_count - COUNT_W'(1));
        end
    end

    // Shared divide step: the remainder starts from zero on every digit.
    assign div_rem_in = (step_reg == '0) ? '0 : rem_reg;

    b62e_divstep u_divstep (
        .rem_in  (div_rem_in),
        .chunk   (n_reg[VALUE_W-1 -: CHUNK_W]),
        .quo     (div_quo),
        .rem_out (div_rem_out)
    );

    // Once the quotient is zero the remaining digits are all zero.
    assign zero_skip  = (state_reg == ST_DIVIDE) && (step_reg == '0) && (n_reg == '0);
    assign last_step  = (step_reg == STEP_W'(STEPS - 1));
    assign digit_done = (state_reg == ST_DIVIDE) && (zero_skip || last_step);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (digit_done && idx_reg == '0) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = (n_reg != '0) ? ST_ERROR : ST_READ;
            end
            ST_READ: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (out_beat) state_next = (idx_reg == last_idx_reg) ? ST_IDLE : ST_READ;
            end
            ST_ERROR: begin
                if (out_beat) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath: dividend, remainder, step and character index.
    always_comb begin
        n_next        = n_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        mem_we        = 1'b0;
        mem_wdata     = div_rem_out;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    n_next        = s_value;
                    step_next     = '0;
                    idx_next      = count_last;
                    last_idx_next = count_last;
                end
            end
            ST_DIVIDE: begin
                if (zero_skip) begin
                    mem_we    = 1'b1;
                    mem_wdata = '0;
                end else begin
                    n_next    = {n_reg[VALUE_W-CHUNK_W-1:0], div_quo};
                    rem_next  = div_rem_out;
                    step_next = last_step ? '0 : step_reg + STEP_W'(1);
                    mem_we    = last_step;
                end
                if (digit_done && idx_reg != '0) idx_next = idx_reg - IDX_W'(1);
            end
            ST_SHOW: begin
                if (out_beat && idx_reg != last_idx_reg) idx_next = idx_reg + IDX_W'(1);
            end
            default: ;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        m_digit_char = '0;
        m_last       = 1'b0;
        m_too_large  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SHOW: begin
                m_valid      = 1'b1;
                m_digit_char = digit_to_ascii(rd_data_reg);
                m_last       = (idx_reg == last_idx_reg);
            end
            ST_ERROR: begin
                m_valid     = 1'b1;
                m_last      = 1'b1;
                m_too_large = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
    end

    // Digit store, filled least significant first and read back in order.
    always_ff @(posedge aclk) begin
        if (mem_we) digit_mem[idx_reg] <= mem_wdata;
        rd_data_reg <= digit_mem[idx_reg];
    end

endmodule

### design/b62e_divstep.sv
module b62e_divstep
    import b62e_pkg::*;
(
    input  logic [REM_W-1:0]   rem_in,
    input  logic [CHUNK_W-1:0] chunk,
    output logic [CHUNK_W-1:0] quo,
    output logic [REM_W-1:0]   rem_out
);

    localparam int V_W    = REM_W + CHUNK_W;
    localparam int PROD_W = V_W + RECIP_SHIFT;

    logic [V_W-1:0]     partial;
    logic [PROD_W-1:0]  prod;
    logic [CHUNK_W-1:0] quo_est;
    logic [V_W-1:0]     rem_wide;
    logic [REM_W:0]     rem_est;

    // The running remainder with the next byte appended.
    assign partial = {rem_in, chunk};

    // Reciprocal estimate: exact or one short of the true quotient.
    assign prod    = PROD_W'(partial) * PROD_W'(RECIP);
    assign quo_est = prod[RECIP_SHIFT +: CHUNK_W];

    // Remainder of the estimate, below twice the radix.
    assign rem_wide = partial - V_W'(quo_est) * V_W'(RADIX);
    assign rem_est  = rem_wide[REM_W:0];

    // One compare and subtract settles the estimate.
    always_comb begin
        if (rem_est >= (REM_W+1)'(RADIX)) begin
            quo     = quo_est + CHUNK_W'(1);
            rem_out = REM_W'(rem_est - (REM_W+1)'(RADIX));
        end else begin
            quo     = quo_est;
            rem_out = rem_est[REM_W-1:0];
        end
    end

endmodule

### design/b62e_checker.sv
module b62e_checker
    import b62e_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [CHAR_W-1:0]  m_digit_char,
    input logic               m_last,
    input logic               m_too_large
);

    // An error beat closes its run and carries no character.
    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_large |-> m_last && m_digit_char == '0)
        else $error("error beat without last or with a character");

    // A normal beat always carries a character of the alphabet.
    a_alphabet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_too_large |->
            (m_digit_char >= 7'h30 && m_digit_char <= 7'h39) ||
            (m_digit_char >= 7'h41 && m_digit_char <= 7'h5A) ||
            (m_digit_char >= 7'h61 && m_digit_char <= 7'h7A))
        else $error("character outside the base-62 alphabet");

    // No new input is taken while a result beat is on offer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    // Having taken an item the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("block not busy after accepting an item");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_char) &&
            $stable(m_last) && $stable(m_too_large))
        else $error("stalled result beat changed");

endmodule

bind base62_fixed_width_encoder b62e_checker u_b62e_checker (.*);
